/* src/bffa_pkg.sv */
// Shared types and constants for the bitmap first-fit allocator.
// No dependencies; imported by bffa_mark_ram, bitmap_first_fit_allocator_unit, the checker and the testbench.
package bffa_pkg;

   // Per-unit mark: bit 1 is the free bit, bit 0 the boundary bit
   typedef logic [1:0] mark_type;

   localparam mark_type MARK_FREE = 2'b11;
   localparam mark_type MARK_HEAD = 2'b01;
   localparam mark_type MARK_CONT = 2'b00;

   localparam int OFS_W      = 14;   // byte offset fields
   localparam int BYTES_W    = 15;   // request size field
   localparam int NEED_W     = 12;   // units needed, up to 2048
   localparam int PAD_W      = 32;   // padding total
   localparam int UNIT_BYTES_LOG2 = 4;
   localparam int RESERVED_UNITS  = 16;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_FREE_CHK,
      ST_FREE_WALK
   } state_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

endpackage

/* src/bffa_mark_ram.sv */
// Unit mark memory: one write port and one read port, registered read data.
// Depends on bffa_pkg for the mark type.
module bffa_mark_ram #(
   parameter int ADDR_W = 10
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  bffa_pkg::mark_type wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output bffa_pkg::mark_type rd_data
);
   import bffa_pkg::*;

   mark_type mem [2**ADDR_W];
   mark_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bitmap_first_fit_allocator_unit.sv */
// Bitmap first-fit allocator: one request at a time, one response per request.
// Allocate: the scan reads the marks from unit 0 up to the first fit, then marks the
// block unit by unit. Free: walks the block up to the next boundary or the heap end. The
// mark memory read port, one unit per cycle, paces both. Responses cannot be stalled.
// Reset (synchronous) starts a pass writing the power-up marks, one unit per cycle,
// over all 2^(HEAP_LOG2-4) units, with busy high; the padding total clears to zero.
module bitmap_first_fit_allocator_unit #(
   parameter int HEAP_LOG2 = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [bffa_pkg::BYTES_W-1:0] req_request_bytes,
   input  logic [bffa_pkg::OFS_W-1:0]   req_block_offset,
   output logic                        rsp_valid,
   output logic [bffa_pkg::OFS_W-1:0]   rsp_granted_offset,
   output logic                        rsp_granted,
   output logic [bffa_pkg::PAD_W-1:0]   rsp_frag_total
);
   import bffa_pkg::*;

   // Unit index width, run counter width (holds the unit count) and compare width
   localparam int UA_W       = HEAP_LOG2 - UNIT_BYTES_LOG2;
   localparam int CNT_W      = UA_W + 1;
   localparam int CMP_W      = (CNT_W > NEED_W) ? CNT_W : NEED_W;
   localparam int MAP_UNITS  = 2 ** (HEAP_LOG2 - 10);
   localparam int OFS_UNIT_W = OFS_W - UNIT_BYTES_LOG2;
   localparam int EXT_W      = UA_W + OFS_UNIT_W;

   localparam logic [UA_W-1:0] LAST_UNIT = {UA_W{1'b1}};

   // Control registers
   state_type                 state_ff, state_in;
   logic [UA_W-1:0]           scan_ff, scan_in;      // init pointer, scan unit, walk unit
   logic [PAD_W-1:0]          pad_ff, pad_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Per-request working registers
   logic [CNT_W-1:0]          run_ff, run_in;
   logic [NEED_W-1:0]         need_ff, need_in;
   logic [UA_W-1:0]           start_ff, start_in;
   logic [UA_W-1:0]           end_ff, end_in;
   logic                      in_range_ff, in_range_in;
   logic [OFS_W-1:0]          rsp_offset_ff, rsp_offset_in;
   logic                      rsp_granted_ff, rsp_granted_in;

   // Memory ports
   logic                      wr_en;
   logic [UA_W-1:0]           wr_addr;
   mark_type                  wr_data;
   logic [UA_W-1:0]           rd_addr;
   mark_type                  rd_data;

   // Helpers
   logic                      accept;
   logic [EXT_W-1:0]          free_unit_ext;
   logic [UA_W-1:0]           free_unit;
   logic                      free_in_range;
   logic [NEED_W+3:0]         bytes_rnd;
   logic [NEED_W-1:0]         need_raw;
   logic [3:0]                pad_rem;
   logic [4:0]                pad_add;
   logic [PAD_W:0]            pad_sum;
   logic [CNT_W-1:0]          run_new;
   logic                      fit;
   logic                      at_last;
   logic [UA_W-1:0]           fit_start;
   logic [NEED_W-1:0]         need_m1;
   mark_type                  init_mark;

   bffa_mark_ram #(
      .ADDR_W (UA_W)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   // Free address: drop the byte bits, check the unit lies inside the heap
   assign free_unit_ext = EXT_W'(req_block_offset[OFS_W-1:UNIT_BYTES_LOG2]);
   assign free_unit     = free_unit_ext[UA_W-1:0];
   assign free_in_range = ((free_unit_ext >> UA_W) == '0);

   // Round the request up to whole units; a zero-byte request takes one unit
   assign bytes_rnd = (NEED_W + 4)'(req_request_bytes) + (NEED_W + 4)'(15);
   assign need_raw  = bytes_rnd[NEED_W+3:4];
   assign pad_rem   = req_request_bytes[3:0];
   assign pad_add   = (pad_rem == 4'd0) ? 5'd0 : (5'd16 - 5'(pad_rem));
   assign pad_sum   = (PAD_W + 1)'(pad_ff) + (PAD_W + 1)'(pad_add);

   // Scan step: extend the free run with the unit just read
   assign run_new   = rd_data[1] ? (run_ff + CNT_W'(1)) : '0;
   assign fit       = (CMP_W'(run_new) >= CMP_W'(need_ff));
   assign at_last   = (scan_ff == LAST_UNIT);
   assign need_m1   = need_ff - NEED_W'(1);
   assign fit_start = scan_ff - UA_W'(need_m1);

   // Power-up mark of the unit under the init pointer
   always_comb begin
      if (scan_ff == '0 || scan_ff == UA_W'(MAP_UNITS)) begin
         init_mark = MARK_HEAD;
      end else if (scan_ff < UA_W'(MAP_UNITS + RESERVED_UNITS)) begin
         init_mark = MARK_CONT;
      end else begin
         init_mark = MARK_FREE;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (at_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_action == ACT_FREE) ? ST_FREE_CHK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (fit) begin
               state_in = ST_MARK;
            end else if (at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (scan_ff == end_ff) state_in = ST_IDLE;
         end
         ST_FREE_CHK: begin
            if (!in_range_ff || rd_data == MARK_CONT || at_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FREE_WALK;
            end
         end
         ST_FREE_WALK: begin
            if (rd_data[0] || at_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      scan_in        = scan_ff;
      pad_in         = pad_ff;
      rsp_valid_in   = 1'b0;
      run_in         = run_ff;
      need_in        = need_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      in_range_in    = in_range_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_granted_in = rsp_granted_ff;
      wr_en          = 1'b0;
      wr_addr        = scan_ff;
      wr_data        = MARK_FREE;
      rd_addr        = scan_ff + UA_W'(1);

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = init_mark;
            scan_in = scan_ff + UA_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               run_in      = '0;
               need_in     = (need_raw == '0) ? NEED_W'(1) : need_raw;
               in_range_in = free_in_range;
               if (req_action == ACT_FREE) begin
                  rd_addr = free_unit;
                  scan_in = free_unit;
               end else begin
                  rd_addr = '0;
                  scan_in = '0;
                  // count padding even if the allocation then fails; saturate
                  pad_in  = pad_sum[PAD_W] ? {PAD_W{1'b1}} : pad_sum[PAD_W-1:0];
               end
            end
         end
         ST_SCAN: begin
            run_in = run_new;
            if (fit) begin
               start_in = fit_start;
               end_in   = scan_ff;
               scan_in  = fit_start;
            end else if (at_last) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
               rsp_offset_in  = '0;
            end else begin
               scan_in = scan_ff + UA_W'(1);
            end
         end
         ST_MARK: begin
            // write the block: head mark first, continuation marks after
            wr_en   = 1'b1;
            wr_data = (scan_ff == start_ff) ? MARK_HEAD : MARK_CONT;
            scan_in = scan_ff + UA_W'(1);
            if (scan_ff == end_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b1;
               rsp_offset_in  = OFS_W'({start_ff, 4'b0000});
            end
         end
         ST_FREE_CHK: begin
            rsp_offset_in = '0;
            if (!in_range_ff || rd_data == MARK_CONT) begin
               // outside the heap or inside a block: drop the request
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
            end else begin
               wr_en   = 1'b1;
               scan_in = scan_ff + UA_W'(1);
               if (at_last) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
               end
            end
         end
         ST_FREE_WALK: begin
            // release continuation units until a boundary or the heap end
            rsp_offset_in = '0;
            if (rd_data[0]) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b1;
            end else begin
               wr_en   = 1'b1;
               scan_in = scan_ff + UA_W'(1);
               if (at_last) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
               end
            end
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         scan_ff      <= '0;
         pad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff         <= run_in;
      need_ff        <= need_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      in_range_ff    <= in_range_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = rsp_offset_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_frag_total     = pad_ff;

endmodule

/* dv/bitmap_first_fit_allocator_checker.sv */
// Response checker for the bitmap first-fit allocator: predicts each response from its
// request and compares it field by field. Depends on bffa_pkg.
module bitmap_first_fit_allocator_checker
   import bffa_pkg::*;
#(
   parameter int HEAP_LOG2 = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_action,
   input  logic [BYTES_W-1:0]   req_request_bytes,
   input  logic [OFS_W-1:0]     req_block_offset,
   input  logic                 rsp_valid,
   input  logic [OFS_W-1:0]     rsp_granted_offset,
   input  logic                 rsp_granted,
   input  logic [PAD_W-1:0]     rsp_frag_total,
   output int                   mismatches,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNITS     = 1 << (HEAP_LOG2 - 4);
   localparam int MAP_UNITS = 1 << (HEAP_LOG2 - 10);

   typedef struct packed {
      logic [OFS_W-1:0] ofs;
      logic             granted;
      logic [PAD_W-1:0] frag;
   } grant_t;

   mark_type         heap_marks [UNITS];
   logic [PAD_W-1:0] pad_sum;
   grant_t           pending_grants [$];
   int               fault_total;

   // Bitmap block at unit 0, reserved block right after it, the rest free
   function automatic void restore_heap();
      int u;
      for (u = 0; u < UNITS; u++) begin
         if (u == 0 || u == MAP_UNITS)
            heap_marks[u] = MARK_HEAD;
         else if (u < MAP_UNITS + RESERVED_UNITS)
            heap_marks[u] = MARK_CONT;
         else
            heap_marks[u] = MARK_FREE;
      end
      pad_sum = '0;
   endfunction

   function automatic grant_t apply_request(action_type act, logic [BYTES_W-1:0] nbytes,
                                            logic [OFS_W-1:0] ofs);
      grant_t       g;
      logic [3:0]   rem;
      logic [32:0]  sum;
      int           need;
      int           run;
      int           first;
      int           byte_ofs;
      int           u;
      int           v;
      g = '0;
      if (act == ACT_ALLOC) begin
         rem = nbytes[3:0];
         if (rem != 4'd0) begin
            sum = {1'b0, pad_sum} + (33'd16 - 33'(rem));
            pad_sum = sum[32] ? '1 : sum[31:0];
         end
         need = (int'(nbytes) + 15) >> 4;
         if (need == 0)
            need = 1;
         run = 0;
         for (u = 0; u < UNITS && !g.granted; u++) begin
            run = heap_marks[u][1] ? run + 1 : 0;
            if (run >= need) begin
               first = u + 1 - need;
               heap_marks[first] = MARK_HEAD;
               for (v = first + 1; v <= u; v++)
                  heap_marks[v] = MARK_CONT;
               byte_ofs = first << 4;
               g.ofs = byte_ofs[OFS_W-1:0];
               g.granted = 1'b1;
            end
         end
      end else begin
         u = int'(ofs >> 4);
         if (u < UNITS && heap_marks[u] != MARK_CONT) begin
            heap_marks[u] = MARK_FREE;
            for (v = u + 1; v < UNITS && heap_marks[v][0] == 1'b0; v++)
               heap_marks[v] = MARK_FREE;
            g.granted = 1'b1;
         end
      end
      g.frag = pad_sum;
      return g;
   endfunction

   always @(posedge clock) begin : watch
      grant_t want;
      if (reset) begin
         restore_heap();
         pending_grants.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               $display("%0t: response with no request waiting: offset %h granted %b frag %h",
                        $time, rsp_granted_offset, rsp_granted, rsp_frag_total);
               fault_total++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_granted_offset !== want.ofs) begin
                  $display("%0t: granted_offset expected %h actual %h",
                           $time, want.ofs, rsp_granted_offset);
                  fault_total++;
               end
               if (rsp_granted !== want.granted) begin
                  $display("%0t: granted expected %b actual %b",
                           $time, want.granted, rsp_granted);
                  fault_total++;
               end
               if (rsp_frag_total !== want.frag) begin
                  $display("%0t: frag_total expected %h actual %h",
                           $time, want.frag, rsp_frag_total);
                  fault_total++;
               end
            end
         end
         if (start && !busy)
            pending_grants.push_back(apply_request(action_type'(req_action),
                                                   req_request_bytes, req_block_offset));
      end
      mismatches  <= fault_total;
      outstanding <= pending_grants.size();
   end

endmodule

/* dv/tb_bitmap_first_fit_allocator_unit.sv */
// Testbench top for bitmap_first_fit_allocator_unit: clock, reset, request stimulus
// and verdict. Depends on bffa_pkg, the block and bitmap_first_fit_allocator_checker.
module tb_bitmap_first_fit_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bffa_pkg::*;

   localparam int     HEAP_LOG2    = 14;
   localparam int     N_RANDOM     = 562;
   localparam int     CALM_TAIL    = 80;      // last requests go out back to back
   localparam int     LIVE_CAP     = 48;      // above this many live blocks, lean on frees
   // Slowest legal run: ~580 requests, each scanning all 1024 units and marking up to
   // ~1000 more, plus idle bursts and the clearing pass after reset; taken ~5x over.
   localparam longint CYCLE_LIMIT  = 64'd6000000;
   // Only one response per request, so a short settle after the last one is enough.
   localparam int     DRAIN_CYCLES = 64;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 start             = 1'b0;
   logic                 req_action        = 1'b0;
   logic [BYTES_W-1:0]   req_request_bytes = '0;
   logic [OFS_W-1:0]     req_block_offset  = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [OFS_W-1:0]     rsp_granted_offset;
   logic                 rsp_granted;
   logic [PAD_W-1:0]     rsp_frag_total;

   int                   mismatches;
   int                   outstanding;
   longint               cycle_count = 0;
   bit                   idle_on     = 1'b1;

   // Stimulus bookkeeping: actions in flight and offsets of blocks handed out
   action_type           issued_actions [$];
   logic [OFS_W-1:0]     live_blocks [$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   bitmap_first_fit_allocator_unit #(
      .HEAP_LOG2(HEAP_LOG2)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted        (rsp_granted),
      .rsp_frag_total     (rsp_frag_total)
   );

   bitmap_first_fit_allocator_checker #(
      .HEAP_LOG2(HEAP_LOG2)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_request_bytes  (req_request_bytes),
      .req_block_offset   (req_block_offset),
      .rsp_valid          (rsp_valid),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted        (rsp_granted),
      .rsp_frag_total     (rsp_frag_total),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   // Watchdog: give up if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_first_fit_allocator_unit verification failed");
         $finish;
      end
   end

   // Collect granted offsets so later frees can name real blocks. Pop the response
   // first, then push the request accepted on the same edge, to keep the order fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && issued_actions.size() != 0) begin
            if (issued_actions.pop_front() == ACT_ALLOC && rsp_granted)
               live_blocks.push_back(rsp_granted_offset);
         end
         if (start && !busy)
            issued_actions.push_back(action_type'(req_action));
      end
   end

   // Present one request and hold it until the block takes it. Afterwards, maybe drop
   // start for a short burst, either right away (the block is busy) or once the block
   // has gone idle, so the gaps land on both phases.
   task automatic send_request(input action_type act, input logic [BYTES_W-1:0] nbytes,
                               input logic [OFS_W-1:0] ofs);
      start             <= 1'b1;
      req_action        <= act;
      req_request_bytes <= nbytes;
      req_block_offset  <= ofs;
      do @(posedge clock); while (busy);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (busy);
         end
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Mostly small blocks so the heap churns; now and then huge or oversized ones
   function automatic logic [BYTES_W-1:0] pick_alloc_bytes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return '0;
      else if (r < 60)
         return BYTES_W'($urandom_range(1, 256));
      else if (r < 85)
         return BYTES_W'($urandom_range(257, 1024));
      else if (r < 95)
         return BYTES_W'($urandom_range(1025, 4096));
      else if (r < 98)
         return BYTES_W'($urandom_range(4097, 16384));
      else
         return BYTES_W'($urandom_range(16385, 32767));
   endfunction

   initial begin : stimulus
      int               n;
      int               r;
      int               idx;
      logic [OFS_W-1:0] ofs;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. After reset units 0..31 are taken (bitmap + reserved block) and
      // allocation starts at unit 32; the comments track the unit layout.
      send_request(ACT_ALLOC, '0, '1);                   // zero bytes -> one unit, 32
      send_request(ACT_ALLOC, 15'd1, '0);                // worst padding, unit 33
      send_request(ACT_ALLOC, 15'd16, '0);               // exact unit, 34
      send_request(ACT_ALLOC, 15'd17, '0);               // two units, 35..36
      send_request(ACT_ALLOC, '1, '0);                   // far beyond the heap, padding kept
      send_request(ACT_ALLOC, 15'd16384, '0);            // whole heap, cannot fit
      send_request(ACT_FREE, '1, OFS_W'(34 * 16 + 7));   // unaligned free of unit 34
      send_request(ACT_FREE, '0, OFS_W'(17 * 16));       // continuation: ignored
      send_request(ACT_FREE, '0, '1);                    // free unit at heap top
      send_request(ACT_FREE, '0, OFS_W'(256));           // release the reserved block
      send_request(ACT_FREE, '0, '0);                    // release the bitmap block
      send_request(ACT_ALLOC, 15'd512, '0);              // refills units 0..31 exactly
      send_request(ACT_ALLOC, 15'd15792, '0);            // 37..1023, ends at the last unit
      send_request(ACT_ALLOC, 15'd16, '0);               // fills the hole at 34
      send_request(ACT_ALLOC, 15'd1, '0);                // heap full
      send_request(ACT_FREE, '0, OFS_W'(37 * 16));       // walk runs out at the heap end
      send_request(ACT_FREE, '0, OFS_W'(33 * 16 + 15));  // unaligned, top of unit 33
      send_request(ACT_ALLOC, 15'd16000, '0);            // just too big for the free run

      // Random part: mostly alloc/free of real blocks, some stray frees and odd sizes
      for (n = 0; n < N_RANDOM; n++) begin
         if (n >= N_RANDOM - CALM_TAIL)
            idle_on = 1'b0;
         else if (n % 40 == 0)
            idle_on = ($urandom_range(0, 3) != 0);

         r = $urandom_range(0, 99);
         if (live_blocks.size() > LIVE_CAP && r < 50)
            r = r + 50;

         if (r < 50 || (r < 85 && live_blocks.size() == 0)) begin
            send_request(ACT_ALLOC, pick_alloc_bytes(), OFS_W'($urandom_range(0, 16383)));
         end else if (r < 85) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            ofs = live_blocks[idx];
            live_blocks.delete(idx);
            if ($urandom_range(0, 3) == 0)
               ofs[3:0] = 4'($urandom_range(0, 15));
            send_request(ACT_FREE, BYTES_W'($urandom_range(0, 32767)), ofs);
         end else if (r < 95) begin
            // stray free: continuation, free unit, bitmap or reserved block alike
            send_request(ACT_FREE, BYTES_W'($urandom_range(0, 32767)),
                         OFS_W'($urandom_range(0, 16383)));
         end else begin
            send_request(ACT_ALLOC, BYTES_W'($urandom_range(0, 32767)),
                         OFS_W'($urandom_range(0, 16383)));
         end
      end
      start <= 1'b0;

      // Drain: wait for the last response, then let the block settle
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("bitmap_first_fit_allocator_unit verification clean");
      else
         $display("bitmap_first_fit_allocator_unit verification failed");
      $finish;
   end

endmodule
